### rtl/core/fevkv_pkg.sv
// ----------------------------------------------------------------------------
// fevkv_pkg
// Shared types and constants for the insertion-ordered key-value table.
// ----------------------------------------------------------------------------
package fevkv_pkg;

  // Default sizes of the table and its words.
  localparam int DEPTH_DEF      = 8;
  localparam int KEY_BITS_DEF   = 32;
  localparam int VALUE_BITS_DEF = 32;

  // Fixed widths of the result fields and the register port.
  localparam int FOUND_BITS = 32;
  localparam int COUNT_OUT_BITS = 4;
  localparam int CAP_BITS   = 4;
  localparam int PADDR_BITS = 3;
  localparam int PDATA_BITS = 32;

  // Register map.
  localparam logic [PADDR_BITS-3:0] REG_CAPACITY = 1'b0;
  localparam logic [CAP_BITS-1:0]   CAP_RESET    = 4'd8;

  // Operation codes.
  typedef enum logic [1:0] {
    FN_INSERT = 2'd0,
    FN_LOOKUP = 2'd1,
    FN_REMOVE = 2'd2,
    FN_NONE   = 2'd3
  } func_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SHIFT,
    ST_APPEND,
    ST_FINISH
  } state_t;

  // Result handed from the sequencer to the output register.
  typedef struct packed {
    logic                      hit;
    logic [FOUND_BITS-1:0]     found_value;
    logic                      evicted;
    logic [COUNT_OUT_BITS-1:0] entries_now;
  } result_t;

endpackage

### rtl/core/fevkv_engine.sv
// ----------------------------------------------------------------------------
// fevkv_engine
// Entry memory and the sequencer that searches, compacts and appends to it.
// ----------------------------------------------------------------------------
module fevkv_engine
  import fevkv_pkg::*;
#(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int KEY_BITS   = KEY_BITS_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            func,
  input  logic [KEY_BITS-1:0]   key,
  input  logic [VALUE_BITS-1:0] value,
  input  logic [CAP_BITS-1:0]   capacity,
  input  logic                  out_free,
  output logic                  res_load,
  output result_t               res
);

  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = (CW > CAP_BITS) ? CW : CAP_BITS;
  localparam int EW   = KEY_BITS + VALUE_BITS;

  state_t state, state_next;

  func_t                 op;
  logic [KEY_BITS-1:0]   key_r;
  logic [VALUE_BITS-1:0] value_r;
  logic [CW-1:0]         count;
  logic [CW-1:0]         ptr;
  logic                  rd_pend;
  logic [AW-1:0]         rd_addr;
  logic                  hit_r;
  logic [FOUND_BITS-1:0] found_r;
  logic                  evict_r;

  // Entry memory: key in the upper bits, value in the lower bits.
  logic [EW-1:0] mem [DEPTH];
  logic [EW-1:0] rd_data;
  logic          mem_re;
  logic [AW-1:0] mem_ra;
  logic          mem_we;
  logic [AW-1:0] mem_wa;
  logic [EW-1:0] mem_wd;

  logic            match;
  logic            full;
  logic [CMPW-1:0] cap_ext;
  logic [CMPW-1:0] cap_eff;
  func_t           in_func;

  assign in_func = func_t'(func);

  // Clamp the capacity to the range one to DEPTH.
  always_comb begin
    cap_ext = CMPW'(capacity);
    if (capacity == '0) begin
      cap_eff = CMPW'(1);
    end else if (cap_ext > CMPW'(DEPTH)) begin
      cap_eff = CMPW'(DEPTH);
    end else begin
      cap_eff = cap_ext;
    end
  end

  assign full  = CMPW'(count) >= cap_eff;
  assign match = rd_data[EW-1:VALUE_BITS] == key_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_data <= mem[mem_ra];
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          case (in_func)
            FN_INSERT: state_next = full ? ST_SHIFT : ST_APPEND;
            FN_LOOKUP, FN_REMOVE: state_next = ST_SCAN;
            default: state_next = ST_FINISH;
          endcase
        end
      end
      ST_SCAN: begin
        if (rd_pend && match) begin
          state_next = (op == FN_LOOKUP) ? ST_FINISH : ST_SHIFT;
        end else if (!rd_pend && ptr == count) begin
          state_next = ST_FINISH;
        end
      end
      ST_SHIFT: begin
        if (!rd_pend && ptr == count) begin
          state_next = (op == FN_INSERT) ? ST_APPEND : ST_FINISH;
        end
      end
      ST_APPEND: state_next = ST_FINISH;
      ST_FINISH: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Memory controls and handshake outputs.
  always_comb begin
    in_stall = state != ST_IDLE;
    res_load = (state == ST_FINISH) && out_free;
    mem_re   = (state == ST_SCAN || state == ST_SHIFT) && (ptr < count);
    mem_ra   = ptr[AW-1:0];
    mem_we   = 1'b0;
    mem_wa   = rd_addr - AW'(1);
    mem_wd   = rd_data;
    case (state)
      ST_SHIFT: mem_we = rd_pend;
      ST_APPEND: begin
        mem_we = 1'b1;
        mem_wa = count[AW-1:0];
        mem_wd = {key_r, value_r};
      end
      default: mem_we = 1'b0;
    endcase
  end

  assign res.hit         = hit_r;
  assign res.found_value = found_r;
  assign res.evicted     = evict_r;
  assign res.entries_now = COUNT_OUT_BITS'(count);

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      count   <= '0;
      rd_pend <= 1'b0;
    end else begin
      state   <= state_next;
      rd_pend <= mem_re;
      case (state)
        ST_SHIFT: begin
          if (!rd_pend && ptr == count) begin
            count <= count - CW'(1);
          end
        end
        ST_APPEND: count <= count + CW'(1);
        default: ;
      endcase
    end
  end

  // Item registers, walk pointer and result fields.
  always_ff @(posedge clk) begin
    rd_addr <= mem_ra;
    if (mem_re) begin
      ptr <= ptr + CW'(1);
    end
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          op      <= in_func;
          key_r   <= key;
          value_r <= value;
          hit_r   <= 1'b0;
          found_r <= '0;
          evict_r <= (in_func == FN_INSERT) && full;
          ptr     <= ((in_func == FN_INSERT) && full) ? CW'(1) : '0;
        end
      end
      ST_SCAN: begin
        // On a remove the read of the entry after the match is already under
        // way, so the compaction simply carries on from the walk pointer.
        if (rd_pend && match) begin
          hit_r <= 1'b1;
          if (op == FN_LOOKUP) begin
            found_r <= FOUND_BITS'(rd_data[VALUE_BITS-1:0]);
          end
        end
      end
      default: ;
    endcase
  end

endmodule

### rtl/core/fifo_evict_key_value_table.sv
// ----------------------------------------------------------------------------
// fifo_evict_key_value_table
// Insertion-ordered key-value table with oldest-first eviction.
// ----------------------------------------------------------------------------
// Each item is an insert, lookup or remove (or the unused code, which does
// nothing) and gives exactly one result item. Entries sit in a single memory
// with one read and one write port, oldest at address zero. A lookup, a
// remove, or an insert that evicts and compacts the entries behind the oldest
// one walks that memory one entry per cycle; an insert that needs no eviction
// goes straight to the append. A new item is taken once the previous one has
// placed its result in the output register, even if that result is still
// waiting to be taken; while the output register holds an untaken result,
// the next result waits for it.
// ----------------------------------------------------------------------------
module fifo_evict_key_value_table
  import fevkv_pkg::*;
#(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int KEY_BITS   = KEY_BITS_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  // Register port
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [PADDR_BITS-1:0]     paddr,
  input  logic [PDATA_BITS-1:0]     pwdata,
  output logic [PDATA_BITS-1:0]     prdata,
  output logic                      pready,
  // Input items
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [1:0]                func,
  input  logic [KEY_BITS-1:0]       key,
  input  logic [VALUE_BITS-1:0]     value,
  // Result items
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic                      hit,
  output logic [FOUND_BITS-1:0]     found_value,
  output logic                      evicted,
  output logic [COUNT_OUT_BITS-1:0] entries_now
);

  logic [CAP_BITS-1:0] capacity;
  logic                sel_cap;
  logic                out_free;
  logic                res_load;
  result_t             res;

  // Register port: one capacity register, no wait states.
  assign pready  = 1'b1;
  assign sel_cap = paddr[PADDR_BITS-1:2] == REG_CAPACITY;
  assign prdata  = sel_cap ? PDATA_BITS'(capacity) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (psel && penable && pwrite && pready && sel_cap) begin
      capacity <= pwdata[CAP_BITS-1:0];
    end
  end

  fevkv_engine #(
    .DEPTH      (DEPTH),
    .KEY_BITS   (KEY_BITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_engine (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .func     (func),
    .key      (key),
    .value    (value),
    .capacity (capacity),
    .out_free (out_free),
    .res_load (res_load),
    .res      (res)
  );

  // Output register: free when empty or being taken this cycle.
  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      hit         <= res.hit;
      found_value <= res.found_value;
      evicted     <= res.evicted;
      entries_now <= res.entries_now;
    end
  end

endmodule

### verif/fifo_evict_key_value_table_tb.sv
// ----------------------------------------------------------------------------
// fifo_evict_key_value_table_tb
// Self-checking bench for the insertion-ordered key-value table.
// ----------------------------------------------------------------------------
// A shadow copy of the table predicts hit, found value, eviction and fill
// level for every accepted item. Each result item is checked against the
// oldest prediction. A short directed run covers empty-table misses, the
// unused operation code, duplicate keys, eviction on a full table, and
// capacities of zero and below the current fill level.
// Random phases follow, each under its own capacity setting, most with random
// gaps on the sending side and random stalls on the receiving side.
// ----------------------------------------------------------------------------
module fifo_evict_key_value_table_tb;
  import fevkv_pkg::*;

  localparam int TIMEOUT_UNITS = 4_000_000;
  localparam int PHASE_ITEMS   = 190;

  logic                      clk;
  logic                      rst;
  logic                      psel;
  logic                      penable;
  logic                      pwrite;
  logic [PADDR_BITS-1:0]     paddr;
  logic [PDATA_BITS-1:0]     pwdata;
  logic [PDATA_BITS-1:0]     prdata;
  logic                      pready;
  logic                      in_valid;
  logic                      in_stall;
  logic [1:0]                func;
  logic [KEY_BITS_DEF-1:0]   key;
  logic [VALUE_BITS_DEF-1:0] value;
  logic                      out_valid;
  logic                      out_stall;
  logic                      hit;
  logic [FOUND_BITS-1:0]     found_value;
  logic                      evicted;
  logic [COUNT_OUT_BITS-1:0] entries_now;

  // Chance, in percent, that a gap or a stall burst starts.
  int unsigned send_gap_pct;
  int unsigned recv_stall_pct;

  // Shadow copy of the table and the queue of results it predicts.
  class kv_shadow_table;
    logic [KEY_BITS_DEF-1:0]   keys   [DEPTH_DEF];
    logic [VALUE_BITS_DEF-1:0] values [DEPTH_DEF];
    int unsigned               fill;
    logic [CAP_BITS-1:0]       capacity;
    result_t                   expected_results [$];
    int unsigned               mismatches;

    function new();
      fill       = 0;
      capacity   = CAP_RESET;
      mismatches = 0;
    endfunction

    function void set_capacity(logic [CAP_BITS-1:0] cap);
      capacity = cap;
    endfunction

    // Removes the entry at pos and closes the gap behind it.
    function void drop_at(int unsigned pos);
      for (int unsigned i = pos + 1; i < fill; i++) begin
        keys[i - 1]   = keys[i];
        values[i - 1] = values[i];
      end
      if (fill > 0) fill--;
    endfunction

    // Applies one accepted item and queues the result it must produce.
    function void note_op(func_t op, logic [KEY_BITS_DEF-1:0] k,
                          logic [VALUE_BITS_DEF-1:0] v);
      result_t     r;
      int unsigned limit;
      r = '0;
      // A capacity of zero acts as one; one above the depth acts as the depth.
      if (capacity == 0) limit = 1;
      else if (capacity > DEPTH_DEF) limit = DEPTH_DEF;
      else limit = capacity;
      case (op)
        FN_INSERT: begin
          // Only the single oldest entry goes, even if the fill is above limit.
          if (fill >= limit) begin
            drop_at(0);
            r.evicted = 1'b1;
          end
          if (fill < DEPTH_DEF) begin
            keys[fill]   = k;
            values[fill] = v;
            fill++;
          end
        end
        FN_LOOKUP: begin
          for (int unsigned i = 0; i < fill; i++) begin
            if (keys[i] == k) begin
              r.hit         = 1'b1;
              r.found_value = values[i];
              break;
            end
          end
        end
        FN_REMOVE: begin
          for (int unsigned i = 0; i < fill; i++) begin
            if (keys[i] == k) begin
              r.hit = 1'b1;
              drop_at(i);
              break;
            end
          end
        end
        default: begin
        end
      endcase
      r.entries_now = COUNT_OUT_BITS'(fill);
      expected_results.push_back(r);
    endfunction

    // Compares one result item with the oldest prediction.
    function void check_result(logic h, logic [FOUND_BITS-1:0] fv, logic ev,
                               logic [COUNT_OUT_BITS-1:0] n);
      result_t want;
      if (expected_results.size() == 0) begin
        $error("result item with nothing pending: hit %0d found_value %0h", h, fv);
        mismatches++;
        return;
      end
      want = expected_results.pop_front();
      if (h !== want.hit) begin
        $error("hit: expected %0d, got %0d", want.hit, h);
        mismatches++;
      end
      if (fv !== want.found_value) begin
        $error("found_value: expected %0h, got %0h", want.found_value, fv);
        mismatches++;
      end
      if (ev !== want.evicted) begin
        $error("evicted: expected %0d, got %0d", want.evicted, ev);
        mismatches++;
      end
      if (n !== want.entries_now) begin
        $error("entries_now: expected %0d, got %0d", want.entries_now, n);
        mismatches++;
      end
    endfunction
  endclass

  kv_shadow_table shadow;

  fifo_evict_key_value_table dut (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .func        (func),
    .key         (key),
    .value       (value),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .hit         (hit),
    .found_value (found_value),
    .evicted     (evicted),
    .entries_now (entries_now)
  );

  // Clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit.
  initial begin
    #(TIMEOUT_UNITS);
    $display("[fifo_evict_key_value_table] ERROR");
    $finish;
  end

  // Receiving side: random stall bursts.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (recv_stall_pct != 0 && $urandom_range(99) < recv_stall_pct) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 13)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Result monitor: values read just after the edge are those the block saw.
  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && out_stall == 1'b0)
      shadow.check_result(hit, found_value, evicted, entries_now);
  end

  // Sends one item, with a random gap in front, and records it on acceptance.
  // Valid stays high afterwards so that back-to-back items need no dip.
  task automatic send_op(func_t op, logic [KEY_BITS_DEF-1:0] k,
                         logic [VALUE_BITS_DEF-1:0] v);
    int unsigned gap;
    gap = 0;
    if (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct)
      gap = $urandom_range(1, 13);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    func     <= op;
    key      <= k;
    value    <= v;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    shadow.note_op(op, k, v);
  endtask

  // Holds the sender back until every predicted result has come out.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (shadow.expected_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Register write: setup cycle, then access until pready.
  task automatic write_capacity(logic [CAP_BITS-1:0] cap);
    logic [PDATA_BITS-1:0] word;
    word = $urandom();
    word[CAP_BITS-1:0] = cap;
    @(posedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {REG_CAPACITY, 2'b00};
    pwdata  <= word;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (pready !== 1'b1) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    shadow.set_capacity(cap);
  endtask

  // Directed opening: edges of the fields and each corner of the behaviour.
  task automatic run_directed();
    send_gap_pct   = 20;
    recv_stall_pct = 20;
    send_op(FN_LOOKUP, 32'h0, 32'h0);
    send_op(FN_REMOVE, 32'hFFFF_FFFF, 32'h0);
    send_op(FN_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_op(FN_INSERT, 32'h0, 32'hFFFF_FFFF);
    send_op(FN_INSERT, 32'hFFFF_FFFF, 32'h0);
    // The same key twice: the older copy must win a lookup.
    send_op(FN_INSERT, 32'h0, 32'h1234_5678);
    send_op(FN_LOOKUP, 32'h0, 32'h0);
    send_op(FN_LOOKUP, 32'hFFFF_FFFF, 32'hA5A5_A5A5);
    send_op(FN_REMOVE, 32'h0, 32'h0);
    send_op(FN_LOOKUP, 32'h0, 32'h0);
    for (int i = 0; i < 6; i++)
      send_op(FN_INSERT, 32'h100 + i, $urandom());
    // Full table: the oldest entry goes.
    send_op(FN_INSERT, 32'hAAAA_5555, 32'h5555_AAAA);
    send_op(FN_LOOKUP, 32'hFFFF_FFFF, 32'h0);
    send_op(FN_REMOVE, 32'h103, 32'h0);
    send_op(FN_NONE, 32'h104, 32'hDEAD_BEEF);
    // Capacity dropped below the fill level: one eviction per insert.
    wait_drained();
    write_capacity(4'd2);
    send_op(FN_INSERT, 32'h200, 32'h1);
    send_op(FN_INSERT, 32'h201, 32'h2);
    send_op(FN_LOOKUP, 32'h201, 32'h0);
    // Capacity of zero behaves as one.
    wait_drained();
    write_capacity(4'd0);
    send_op(FN_INSERT, 32'h300, 32'h3);
    send_op(FN_REMOVE, 32'h300, 32'h0);
  endtask

  // One random phase under a given capacity, keys mostly from a small pool.
  task automatic run_random_phase(logic [CAP_BITS-1:0] cap, int unsigned gap_pct,
                                  int unsigned stall_pct, bit pause_midway);
    logic [KEY_BITS_DEF-1:0] pool [6];
    logic [KEY_BITS_DEF-1:0] k;
    func_t                   op;
    int unsigned             pick;
    wait_drained();
    write_capacity(cap);
    send_gap_pct   = gap_pct;
    recv_stall_pct = stall_pct;
    foreach (pool[i]) pool[i] = $urandom();
    pool[0] = $urandom_range(1) ? '0 : '1;
    for (int unsigned n = 0; n < PHASE_ITEMS; n++) begin
      pick = $urandom_range(99);
      if (pick < 42) op = FN_INSERT;
      else if (pick < 72) op = FN_LOOKUP;
      else if (pick < 94) op = FN_REMOVE;
      else op = FN_NONE;
      k = ($urandom_range(99) < 85) ? pool[$urandom_range(5)] : $urandom();
      if (pause_midway && n == PHASE_ITEMS / 2) wait_drained();
      send_op(op, k, $urandom());
    end
  endtask

  // Main sequence.
  initial begin
    shadow         = new();
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    rst      = 1'b1;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    in_valid = 1'b0;
    func     = FN_INSERT;
    key      = '0;
    value    = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    run_directed();
    run_random_phase(4'd15, 25, 25, 1'b0);
    run_random_phase(4'd1, 40, 10, 1'b1);
    run_random_phase(4'd3, 0, 0, 1'b0);
    run_random_phase(4'd8, 15, 45, 1'b0);
    run_random_phase(4'd0, 30, 30, 1'b0);
    run_random_phase(4'd5, 50, 5, 1'b0);
    run_random_phase(4'd2, 10, 20, 1'b0);
    // Closing stretch without gaps or stalls.
    run_random_phase(4'd8, 0, 0, 1'b0);

    wait_drained();
    repeat (30) @(posedge clk);
    if (shadow.mismatches == 0 && shadow.expected_results.size() == 0) begin
      $display("[fifo_evict_key_value_table] OK");
    end else begin
      $display("[fifo_evict_key_value_table] ERROR");
    end
    $finish;
  end

endmodule
